// ===== src/mcet_pkg.sv =====
`timescale 1ns / 1ps
package mcet_pkg;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_CREATE = 2'd1,
    OP_KILL   = 2'd2,
    OP_TIME   = 2'd3
  } op_e;

  localparam logic [0:0]  REG_TICK_STEP   = 1'b0;
  localparam logic [0:0]  REG_START_TIME  = 1'b1;
  localparam logic [9:0]  TICK_STEP_RESET = 10'd10;
  localparam logic [15:0] MAX_ID          = 16'hFFFF;
  localparam int          MAX_RESULTS     = 16;
  localparam logic [1:0]  CK_UNKNOWN      = 2'd3;

  // Mode word: bit 0 one-shot, bits 2:1 callback kind, bit 3 native.
  typedef struct packed {
    op_e         op;
    logic [15:0] delay;
    logic [31:0] handler;
    logic [31:0] user;
    logic [3:0]  mode;
    logic [15:0] kill_id;
  } cmd_t;

  typedef struct packed {
    logic        status;
    logic [15:0] timer_id;
    logic [31:0] handler;
    logic [31:0] user;
    logic [1:0]  kind;
    logic        native;
    logic [31:0] sys_time;
    logic        last;
  } res_t;

endpackage

// ===== src/mcet_front.sv =====
`timescale 1ns / 1ps
module mcet_front import mcet_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [15:0] delay_i,
  input  logic [31:0] handler_i,
  input  logic [31:0] user_value_i,
  input  logic        one_shot_i,
  input  logic [1:0]  callback_kind_i,
  input  logic        native_call_i,
  input  logic [15:0] kill_id_i,
  output logic        q_valid_o,
  output cmd_t        q_cmd_o,
  input  logic        q_pop_i
);

  cmd_t       buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  cmd_t       cmd;
  logic       push;

  always_comb begin
    cmd         = '0;
    cmd.op      = op_e'(kind_i);
    cmd.delay   = delay_i;
    cmd.handler = handler_i;
    cmd.user    = user_value_i;
    cmd.mode    = {native_call_i, callback_kind_i, one_shot_i};
    cmd.kill_id = kill_id_i;
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_cmd_o    = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_ptr_q] <= cmd;
  end

endmodule

// ===== src/mcet_back.sv =====
`timescale 1ns / 1ps
module mcet_back import mcet_pkg::*; #(
  parameter int NUM_TIMERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        q_valid_i,
  input  cmd_t        q_cmd_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output res_t        out_res_o
);

  localparam int SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(NUM_TIMERS + 1);

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] period;
    logic [15:0] remain;
    logic [31:0] handler;
    logic [31:0] user;
    logic [3:0]  mode;
  } ent_t;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_EXEC, S_FINAL} state_e;

  state_e          state_q;
  ent_t            mem [NUM_TIMERS];
  ent_t            rd_q;
  logic [SW-1:0]   order_q [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] valid_q;
  logic [CW-1:0]   cnt_q;
  logic [SW-1:0]   walk_q;
  logic [9:0]      step_q;
  logic [31:0]     clock_q;
  logic [4:0]      n_q;
  logic            pend_v_q;
  res_t            pend_q;
  logic            out_valid_q;
  res_t            out_q;

  logic          out_free, rd_en, wr_en, fire, audible, tick_go, create_ok, cr_now;
  logic          last_pos;
  logic [SW-1:0] rd_addr, wr_addr, free_idx, cur_slot;
  ent_t          wr_data;
  res_t          fire_res;
  res_t          pend_last;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign cur_slot    = order_q[walk_q];
  assign last_pos    = (CW'(walk_q) + CW'(1) == cnt_q);

  function automatic res_t mk(logic st, logic [15:0] id, logic [31:0] t, logic lst);
    res_t r;
    r = '0;
    r.status   = st;
    r.timer_id = id;
    r.sys_time = t;
    r.last     = lst;
    return r;
  endfunction

  always_comb begin
    free_idx = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_idx = SW'(i);
    end
    fire      = ({6'd0, step_q} > rd_q.remain);
    audible   = fire && (rd_q.mode[2:1] != CK_UNKNOWN) && (rd_q.handler != '0) &&
                (n_q < 5'(MAX_RESULTS));
    tick_go   = !(audible && pend_v_q && !out_free);
    create_ok = (cnt_q != CW'(NUM_TIMERS)) && (rd_q.id != MAX_ID);
    cr_now    = (state_q == S_IDLE) && q_valid_i && (q_cmd_i.op == OP_CREATE) &&
                (cnt_q == '0) && out_free;
    fire_res          = '0;
    fire_res.timer_id = rd_q.id;
    fire_res.handler  = rd_q.handler;
    fire_res.user     = rd_q.user;
    fire_res.kind     = rd_q.mode[2:1];
    fire_res.native   = rd_q.mode[3];
    fire_res.sys_time = clock_q;
    pend_last         = pend_q;
    pend_last.last    = 1'b1;
    rd_en   = (state_q == S_READ);
    rd_addr = cur_slot;
    wr_en   = 1'b0;
    wr_addr = free_idx;
    wr_data = rd_q;
    if (cr_now || ((state_q == S_EXEC) && (q_cmd_i.op == OP_CREATE) && create_ok &&
                   out_free)) begin
      wr_en          = 1'b1;
      wr_data.id     = cr_now ? 16'd1 : rd_q.id + 16'd1;
      wr_data.period = q_cmd_i.delay;
      wr_data.remain = q_cmd_i.delay;
      wr_data.handler = q_cmd_i.handler;
      wr_data.user   = q_cmd_i.user;
      wr_data.mode   = q_cmd_i.mode;
    end else if ((state_q == S_EXEC) && (q_cmd_i.op == OP_TICK) && tick_go) begin
      wr_en          = 1'b1;
      wr_addr        = cur_slot;
      wr_data.remain = fire ? rd_q.period : rd_q.remain - {6'd0, step_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      cnt_q       <= '0;
      walk_q      <= '0;
      step_q      <= TICK_STEP_RESET;
      clock_q     <= '0;
      n_q         <= '0;
      pend_v_q    <= 1'b0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      q_pop_o     <= 1'b0;
      for (int j = 0; j < NUM_TIMERS; j++) order_q[j] <= '0;
    end else begin
      q_pop_o <= 1'b0;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i && !q_pop_o) begin
            unique case (q_cmd_i.op)
              OP_TIME: begin
                if (out_free) begin
                  out_valid_q <= 1'b1;
                  out_q       <= mk(1'b0, 16'd0, clock_q, 1'b1);
                  q_pop_o     <= 1'b1;
                end
              end
              OP_CREATE: begin
                if (cnt_q == '0) begin
                  if (out_free) begin
                    valid_q[free_idx] <= 1'b1;
                    order_q[0]        <= free_idx;
                    cnt_q             <= CW'(1);
                    out_valid_q       <= 1'b1;
                    out_q             <= mk(1'b0, 16'd1, clock_q, 1'b1);
                    q_pop_o           <= 1'b1;
                  end
                end else begin
                  walk_q  <= SW'(cnt_q - CW'(1));
                  state_q <= S_READ;
                end
              end
              OP_KILL: begin
                if (cnt_q == '0) begin
                  if (out_free) begin
                    out_valid_q <= 1'b1;
                    out_q       <= mk(1'b1, q_cmd_i.kill_id, clock_q, 1'b1);
                    q_pop_o     <= 1'b1;
                  end
                end else begin
                  walk_q  <= '0;
                  state_q <= S_READ;
                end
              end
              default: begin
                clock_q  <= clock_q + {22'd0, step_q};
                n_q      <= '0;
                pend_v_q <= 1'b0;
                walk_q   <= SW'(cnt_q - CW'(1));
                state_q  <= (cnt_q == '0) ? S_FINAL : S_READ;
              end
            endcase
          end
        end
        S_READ: state_q <= S_EXEC;
        S_EXEC: begin
          unique case (q_cmd_i.op)
            OP_CREATE: begin
              if (out_free) begin
                out_valid_q <= 1'b1;
                if (create_ok) begin
                  valid_q[free_idx]   <= 1'b1;
                  order_q[SW'(cnt_q)] <= free_idx;
                  cnt_q               <= cnt_q + CW'(1);
                  out_q <= mk(1'b0, rd_q.id + 16'd1, clock_q, 1'b1);
                end else begin
                  out_q <= mk(1'b1, 16'd0, clock_q, 1'b1);
                end
                q_pop_o <= 1'b1;
                state_q <= S_IDLE;
              end
            end
            OP_KILL: begin
              if (rd_q.id == q_cmd_i.kill_id) begin
                if (out_free) begin
                  valid_q[cur_slot] <= 1'b0;
                  for (int j = 0; j < NUM_TIMERS - 1; j++) begin
                    if (j >= int'(walk_q)) order_q[j] <= order_q[j+1];
                  end
                  cnt_q       <= cnt_q - CW'(1);
                  out_valid_q <= 1'b1;
                  out_q       <= mk(1'b0, q_cmd_i.kill_id, clock_q, 1'b1);
                  q_pop_o     <= 1'b1;
                  state_q     <= S_IDLE;
                end
              end else if (last_pos) begin
                if (out_free) begin
                  out_valid_q <= 1'b1;
                  out_q       <= mk(1'b1, q_cmd_i.kill_id, clock_q, 1'b1);
                  q_pop_o     <= 1'b1;
                  state_q     <= S_IDLE;
                end
              end else begin
                walk_q  <= walk_q + SW'(1);
                state_q <= S_READ;
              end
            end
            default: begin
              if (tick_go) begin
                if (audible) begin
                  // The previous firing is not the last one, so it goes out now.
                  if (pend_v_q) begin
                    out_valid_q <= 1'b1;
                    out_q       <= pend_q;
                  end
                  pend_q   <= fire_res;
                  pend_v_q <= 1'b1;
                  n_q      <= n_q + 5'd1;
                end
                if (fire && rd_q.mode[0]) begin
                  valid_q[cur_slot] <= 1'b0;
                  for (int j = 0; j < NUM_TIMERS - 1; j++) begin
                    if (j >= int'(walk_q)) order_q[j] <= order_q[j+1];
                  end
                  cnt_q <= cnt_q - CW'(1);
                end
                if (walk_q == '0) begin
                  state_q <= S_FINAL;
                end else begin
                  walk_q  <= walk_q - SW'(1);
                  state_q <= S_READ;
                end
              end
            end
          endcase
        end
        default: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (pend_v_q) begin
              out_q <= pend_last;
            end else begin
              out_q <= mk(1'b0, 16'd0, clock_q, 1'b1);
            end
            q_pop_o <= 1'b1;
            state_q <= S_IDLE;
          end
        end
      endcase
      if (cfg_we_i) begin
        if (cfg_index_i == REG_TICK_STEP) step_q <= cfg_data_i[9:0];
        if (cfg_index_i == REG_START_TIME) clock_q <= cfg_data_i;
      end
    end
  end

endmodule

// ===== src/multi_channel_event_timer_top.sv =====
`timescale 1ns / 1ps
// Table of periodic and one-shot timers.
// Input channel (in_valid_i / in_stall_o) takes one command beat: tick,
// create, kill or read system time. Output channel (out_valid_o /
// out_stall_i) gives result beats; last_o marks the final beat of a command.
// Commands pass through a two-entry queue into an executor that reads the
// timer memory one entry at a time, in a read state and an execute state.
// Read time and a create on an empty table are answered from the idle state;
// any other create first reads the newest entry, a kill searches entry by
// entry for its id, and a tick walks every live timer. One command executes
// at a time.
// A tick gives one beat per audible firing (at most 16), newest timer
// first, or one quiet beat when nothing fires audibly.
// Reset empties the table and the queue, sets the tick step to 10 ms and
// the system time to zero. No clearing pass is needed.
// When the receiver stalls, the output register holds its beat and the
// executor stalls at its next beat; the queue takes commands until full.
// Configuration: index 0 tick step, index 1 loads the system time.
module multi_channel_event_timer_top import mcet_pkg::*; #(
  parameter int NUM_TIMERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [15:0] delay_i,
  input  logic [31:0] handler_i,
  input  logic [31:0] user_value_i,
  input  logic        one_shot_i,
  input  logic [1:0]  callback_kind_i,
  input  logic        native_call_i,
  input  logic [15:0] kill_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic [15:0] timer_id_o,
  output logic [31:0] fired_handler_o,
  output logic [31:0] fired_user_o,
  output logic [1:0]  fired_kind_o,
  output logic        fired_native_o,
  output logic [31:0] system_time_o,
  output logic        last_o
);

  logic q_valid, q_pop;
  cmd_t q_cmd;
  res_t res;

  mcet_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .delay_i, .handler_i,
    .user_value_i, .one_shot_i, .callback_kind_i, .native_call_i, .kill_id_i,
    .q_valid_o(q_valid), .q_cmd_o(q_cmd), .q_pop_i(q_pop)
  );

  mcet_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .q_valid_i(q_valid), .q_cmd_i(q_cmd), .q_pop_o(q_pop),
    .out_valid_o, .out_stall_i, .out_res_o(res)
  );

  assign status_o        = res.status;
  assign timer_id_o      = res.timer_id;
  assign fired_handler_o = res.handler;
  assign fired_user_o    = res.user;
  assign fired_kind_o    = res.kind;
  assign fired_native_o  = res.native;
  assign system_time_o   = res.sys_time;
  assign last_o          = res.last;

endmodule

// ===== tb/tb_multi_channel_event_timer_top.sv =====
`timescale 1ns / 1ps
module tb_multi_channel_event_timer_top;
  import mcet_pkg::*;

  localparam int NT = 16;

  typedef struct packed {
    logic        status;
    logic [15:0] timer_id;
    logic [31:0] handler;
    logic [31:0] user;
    logic [1:0]  kind;
    logic        native;
    logic [31:0] sys_time;
    logic        last;
  } beat_t;

  class timer_scoreboard;
    bit          live [NT];
    logic [15:0] id [NT];
    logic [15:0] period [NT];
    logic [15:0] remain [NT];
    logic [31:0] hnd [NT];
    logic [31:0] usr [NT];
    logic [3:0]  mode [NT];
    logic [31:0] clock_ms;
    logic [9:0]  step;
    beat_t       pending [$];
    int          errors;

    function void reset_state();
      for (int i = 0; i < NT; i++) live[i] = 0;
      clock_ms = 0;
      step = TICK_STEP_RESET;
      pending.delete();
      errors = 0;
    endfunction

    function void push(logic st, logic [15:0] tid, logic [31:0] h, logic [31:0] u,
                       logic [1:0] k, logic nat);
      beat_t b;
      b.status = st; b.timer_id = tid; b.handler = h; b.user = u;
      b.kind = k; b.native = nat; b.sys_time = clock_ms; b.last = 0;
      pending.push_back(b);
    endfunction

    function void note_command(op_e op, logic [15:0] dly, logic [31:0] h,
                               logic [31:0] u, logic os, logic [1:0] ck,
                               logic nat, logic [15:0] kid);
      int maxid, free_slot, pick, made;
      int bound, best;
      bit st;
      made = 0;
      case (op)
        OP_CREATE: begin
          maxid = 0; free_slot = -1;
          for (int i = 0; i < NT; i++)
            if (live[i]) begin
              if (id[i] > maxid) maxid = id[i];
            end else if (free_slot < 0) free_slot = i;
          if (free_slot < 0 || maxid >= MAX_ID) push(1, 0, 0, 0, 0, 0);
          else begin
            live[free_slot] = 1; id[free_slot] = maxid + 1;
            period[free_slot] = dly; remain[free_slot] = dly;
            hnd[free_slot] = h; usr[free_slot] = u;
            mode[free_slot] = {nat, ck, os};
            push(0, maxid + 1, 0, 0, 0, 0);
          end
        end
        OP_KILL: begin
          st = 1;
          for (int i = 0; i < NT; i++)
            if (live[i] && id[i] == kid) begin
              live[i] = 0; st = 0; break;
            end
          push(st, kid, 0, 0, 0, 0);
        end
        OP_TIME: push(0, 0, 0, 0, 0, 0);
        default: begin
          clock_ms = clock_ms + step;
          bound = 65536;
          forever begin
            pick = -1; best = 0;
            for (int i = 0; i < NT; i++)
              if (live[i] && id[i] < bound && (pick < 0 || id[i] > best)) begin
                pick = i; best = id[i];
              end
            if (pick < 0) break;
            bound = best;
            if (remain[pick] < step) begin
              remain[pick] = period[pick];
              if (mode[pick][2:1] != CK_UNKNOWN && hnd[pick] != 0 && made < MAX_RESULTS)
              begin
                push(0, id[pick], hnd[pick], usr[pick], mode[pick][2:1], mode[pick][3]);
                made++;
              end
              if (mode[pick][0]) live[pick] = 0;
            end else remain[pick] = remain[pick] - step;
          end
          if (made == 0) push(0, 0, 0, 0, 0, 0);
        end
      endcase
      pending[pending.size() - 1].last = 1;
    endfunction

    function void check_beat(beat_t got);
      beat_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat id=%h", $time, got.timer_id);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        $display("%0t: mismatch expected st=%b id=%h h=%h u=%h k=%h n=%b t=%h l=%b",
                 $time, e.status, e.timer_id, e.handler, e.user, e.kind, e.native,
                 e.sys_time, e.last);
        $display("%0t:          actual   st=%b id=%h h=%h u=%h k=%h n=%b t=%h l=%b",
                 $time, got.status, got.timer_id, got.handler, got.user, got.kind,
                 got.native, got.sys_time, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [0:0]  cfg_index_i = 0;
  logic [31:0] cfg_data_i = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [1:0]  kind_i = 0;
  logic [15:0] delay_i = 0;
  logic [31:0] handler_i = 0;
  logic [31:0] user_value_i = 0;
  logic        one_shot_i = 0;
  logic [1:0]  callback_kind_i = 0;
  logic        native_call_i = 0;
  logic [15:0] kill_id_i = 0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic        status_o;
  logic [15:0] timer_id_o;
  logic [31:0] fired_handler_o;
  logic [31:0] fired_user_o;
  logic [1:0]  fired_kind_o;
  logic        fired_native_o;
  logic [31:0] system_time_o;
  logic        last_o;

  timer_scoreboard board;
  bit calm;

  always #1 clk_i = ~clk_i;

  multi_channel_event_timer_top u_top (.*);

  // Result side: stall at random except during the calm stretch.
  always @(negedge clk_i) begin
    if (rst_ni) out_stall_i <= !calm && ($urandom_range(99) < 26);
  end

  always @(posedge clk_i) begin
    beat_t b;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      b.status = status_o; b.timer_id = timer_id_o; b.handler = fired_handler_o;
      b.user = fired_user_o; b.kind = fired_kind_o; b.native = fired_native_o;
      b.sys_time = system_time_o; b.last = last_o;
      board.check_beat(b);
    end
  end

  // Valid stays high after the accepting edge until the next beat, an idle
  // cycle or a drain takes over at the following falling edge.
  task automatic send(op_e op, logic [15:0] dly, logic [31:0] h, logic [31:0] u,
                      logic os, logic [1:0] ck, logic nat, logic [15:0] kid);
    while (!calm && $urandom_range(99) < 26) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1; kind_i <= op; delay_i <= dly; handler_i <= h;
    user_value_i <= u; one_shot_i <= os; callback_kind_i <= ck;
    native_call_i <= nat; kill_id_i <= kid;
    do @(posedge clk_i); while (in_stall_o);
    board.note_command(op, dly, h, u, os, ck, nat, kid);
    @(negedge clk_i);
  endtask

  task automatic tick();
    send(OP_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic make(logic [15:0] dly, logic [31:0] h, logic os, logic [1:0] ck);
    send(OP_CREATE, dly, h, $urandom, os, ck, $urandom, $urandom);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    cfg_we_i <= 1; cfg_index_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 0;
    if (idx == REG_TICK_STEP) board.step = val[9:0];
    else board.clock_ms = val;
  endtask

  task automatic random_item(int pk);
    int r;
    r = $urandom_range(99);
    if (r < 40) tick();
    else if (r < 70)
      make($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 60),
           $urandom_range(0, 9) == 0 ? 32'd0 : $urandom, $urandom, $urandom);
    else if (r < 90)
      send(OP_KILL, 0, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, pk + 2));
    else send(OP_TIME, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    board = new();
    board.reset_state();
    calm = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // Directed: every operation, silent kinds, null handler, one-shot, extremes.
    send(OP_TIME, 0, 0, 0, 0, 0, 0, 0);
    tick();
    send(OP_KILL, 0, 0, 0, 0, 0, 0, 16'd0);
    make(16'd0, 32'hFFFF_FFFF, 1, 2'd0);
    make(16'd5, 32'h1, 0, 2'd1);
    make(16'hFFFF, 32'h8000_0000, 0, 2'd2);
    make(16'd0, 32'h1234, 0, CK_UNKNOWN);
    make(16'd0, 32'd0, 1, 2'd1);
    send(OP_CREATE, 16'd3, 32'hA5A5, 32'hFFFF_FFFF, 0, 2'd0, 1, 16'hFFFF);
    tick(); tick();
    send(OP_KILL, 0, 0, 0, 0, 0, 0, 16'd2);
    send(OP_KILL, 0, 0, 0, 0, 0, 0, 16'd2);
    send(OP_KILL, 0, 0, 0, 0, 0, 0, 16'hFFFF);
    // Fill the table to full, then a tick with many audible firings.
    for (int i = 0; i < 13; i++) make(16'd0, 32'h100 + i, 0, i % 3);
    tick(); tick();
    drain();

    write_reg(REG_TICK_STEP, 32'd1000);
    write_reg(REG_START_TIME, 32'hFFFF_FF00);
    tick(); tick(); send(OP_TIME, 0, 0, 0, 0, 0, 0, 0);
    for (int i = 1; i < 30; i++) send(OP_KILL, 0, 0, 0, 0, 0, 0, i);
    drain();
    write_reg(REG_TICK_STEP, 32'd0);
    make(16'd0, 32'h55, 0, 2'd0);
    tick();
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_reg(REG_TICK_STEP, 32'd1);
        1: write_reg(REG_TICK_STEP, $urandom_range(2, 40));
        2: write_reg(REG_TICK_STEP, 32'h3FF);
        default: write_reg(REG_TICK_STEP, 32'd10);
      endcase
      write_reg(REG_START_TIME, $urandom);
      calm = (ph == 2);
      for (int k = 0; k < 64; k++) random_item(40 + ph * 30);
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
